[hw/rtl/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, constants and the arctangent table for the CORDIC sine and
// cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned MaxIter   = 32;
  localparam int unsigned IterW     = 6;
  localparam int unsigned AngleW    = 33;
  localparam int unsigned XyW       = 32;
  localparam int unsigned ZW        = 34;
  localparam int unsigned StageIdxW = $clog2(MaxIter);

  localparam logic [IterW-1:0] IterReset = IterW'(17);

  localparam logic signed [XyW-1:0] InvGain = XyW'(32'h26DD3B6A);
  localparam logic signed [ZW-1:0]  HalfPi  = ZW'(34'h06487ED51);
  localparam logic signed [ZW-1:0]  PiFixed = ZW'(34'h0C90FDAA2);

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  flip;
  } csc_vec_t;

  function automatic logic [XyW-1:0] atan_lut(input logic [StageIdxW-1:0] k);
    logic [XyW-1:0] a;
    unique case (k)
      5'd0:    a = 32'h3243F6A8;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFC;
      5'd3:    a = 32'h07F56EA6;
      5'd4:    a = 32'h03FEAB76;
      5'd5:    a = 32'h01FFD55B;
      5'd6:    a = 32'h00FFFAAA;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEA;
      5'd9:    a = 32'h001FFFFD;
      5'd10:   a = 32'h000FFFFF;
      5'd11:   a = 32'h0007FFFF;
      5'd12:   a = 32'h0003FFFF;
      5'd13:   a = 32'h0001FFFF;
      5'd14:   a = 32'h0000FFFF;
      5'd15:   a = 32'h00007FFF;
      5'd16:   a = 32'h00003FFF;
      5'd17:   a = 32'h00001FFF;
      5'd18:   a = 32'h00000FFF;
      5'd19:   a = 32'h000007FF;
      5'd20:   a = 32'h000003FF;
      5'd21:   a = 32'h000001FF;
      5'd22:   a = 32'h000000FF;
      5'd23:   a = 32'h0000007F;
      5'd24:   a = 32'h0000003F;
      5'd25:   a = 32'h0000001F;
      5'd26:   a = 32'h0000000F;
      5'd27:   a = 32'h00000008;
      5'd28:   a = 32'h00000004;
      5'd29:   a = 32'h00000002;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/csc_rotator.sv]
// ----------------------------------------------------------------------------
// csc_rotator
// Unrolled rotation-mode CORDIC: one registered micro-rotation per stage,
// with a valid bit per stage and a ready chain that fills bubbles.
// ----------------------------------------------------------------------------
module csc_rotator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [csc_pkg::IterW-1:0]           iter_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  csc_pkg::csc_vec_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output csc_pkg::csc_vec_t                   out_data_o
);

  localparam int unsigned N = csc_pkg::MaxIter;

  logic              v_q   [N];
  csc_pkg::csc_vec_t d_q   [N];
  logic              rdy   [N+1];

  assign rdy[N] = out_ready_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       prev_v;
    csc_pkg::csc_vec_t          prev_d;
    csc_pkg::csc_vec_t          rot_d;
    logic signed [csc_pkg::XyW-1:0] xs;
    logic signed [csc_pkg::XyW-1:0] ys;
    logic signed [csc_pkg::ZW-1:0]  a;

    if (k == 0) begin : g_first
      assign prev_v = in_valid_i;
      assign prev_d = in_data_i;
    end else begin : g_next
      assign prev_v = v_q[k-1];
      assign prev_d = d_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    assign xs = prev_d.x >>> k;
    assign ys = prev_d.y >>> k;
    assign a  = csc_pkg::ZW'(csc_pkg::atan_lut(csc_pkg::StageIdxW'(k)));

    always_comb begin
      rot_d = prev_d;
      if (csc_pkg::IterW'(k) < iter_i) begin
        if (prev_d.z[csc_pkg::ZW-1]) begin
          rot_d.x = prev_d.x + ys;
          rot_d.y = prev_d.y - xs;
          rot_d.z = prev_d.z + a;
        end else begin
          rot_d.x = prev_d.x - ys;
          rot_d.y = prev_d.y + xs;
          rot_d.z = prev_d.z - a;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && prev_v) begin
        d_q[k] <= rot_d;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[N-1];
  assign out_data_o  = d_q[N-1];

endmodule

[hw/rtl/cordic_sine_cosine.sv]
// ----------------------------------------------------------------------------
// cordic_sine_cosine
// Sine and cosine of a fixed-point angle (30 fraction bits) by rotation-mode
// CORDIC: fold stage, 32 unrolled micro-rotation stages, output stage.
// ----------------------------------------------------------------------------
// One angle is taken per clock cycle while s_axis_tready is high; each result
// passes one fold stage, one register for each of the 32 micro-rotation stages
// and one output register. The latency does not depend on iteration_count;
// stages at or beyond the count pass their values through. Stalls on the output
// are absorbed stage by stage, so empty stages still accept new angles while a
// result waits.
module cordic_sine_cosine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // iteration_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [32:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata     // [31:0] sine, [63:32] cosine
);

  logic [csc_pkg::IterW-1:0] iter_q;
  logic [csc_pkg::IterW-1:0] iter_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= csc_pkg::IterReset;
    end else if (cfg_we_i) begin
      iter_q <= cfg_wdata_i;
    end
  end

  assign iter_n = (iter_q > csc_pkg::IterW'(csc_pkg::MaxIter))
                ? csc_pkg::IterW'(csc_pkg::MaxIter) : iter_q;

  // fold stage
  logic                           f_v_q;
  csc_pkg::csc_vec_t              f_q;
  csc_pkg::csc_vec_t              f_d;
  logic                           f_rdy;
  logic signed [csc_pkg::ZW-1:0]  z_in;
  logic                           rot_in_ready;

  assign z_in = csc_pkg::ZW'(signed'(s_axis_tdata[csc_pkg::AngleW-1:0]));

  always_comb begin
    f_d.x    = csc_pkg::InvGain;
    f_d.y    = '0;
    f_d.z    = z_in;
    f_d.flip = 1'b0;
    if (z_in > csc_pkg::HalfPi) begin
      f_d.z    = z_in - csc_pkg::PiFixed;
      f_d.flip = 1'b1;
    end else if (z_in < -csc_pkg::HalfPi) begin
      f_d.z    = z_in + csc_pkg::PiFixed;
      f_d.flip = 1'b1;
    end
  end

  assign f_rdy         = !f_v_q || rot_in_ready;
  assign s_axis_tready = f_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (f_rdy) begin
      f_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && s_axis_tvalid) begin
      f_q <= f_d;
    end
  end

  // rotation pipeline
  logic              rot_out_valid;
  csc_pkg::csc_vec_t rot_out;
  logic              o_rdy;

  csc_rotator u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iter_i      (iter_n),
    .in_valid_i  (f_v_q),
    .in_ready_o  (rot_in_ready),
    .in_data_i   (f_q),
    .out_valid_o (rot_out_valid),
    .out_ready_i (o_rdy),
    .out_data_o  (rot_out)
  );

  // output stage, sign restore for folded angles
  logic                  o_v_q;
  logic [csc_pkg::XyW-1:0] sin_q;
  logic [csc_pkg::XyW-1:0] cos_q;
  logic [csc_pkg::XyW-1:0] sin_d;
  logic [csc_pkg::XyW-1:0] cos_d;

  assign sin_d = rot_out.flip ? (csc_pkg::XyW'(0) - rot_out.y) : rot_out.y;
  assign cos_d = rot_out.flip ? (csc_pkg::XyW'(0) - rot_out.x) : rot_out.x;
  assign o_rdy = !o_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_rdy) begin
      o_v_q <= rot_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && rot_out_valid) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {cos_q, sin_q};

  // checks
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> (f_q.z <= csc_pkg::HalfPi && f_q.z >= -csc_pkg::HalfPi))
    else $error("folded angle outside half pi");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rot_out_valid))
    else $error("result without a pipeline transaction");

endmodule
